// File: design/slv_pkg.sv
`default_nettype none

package slv_pkg;

    // Field widths of the channels and registers.
    localparam int COMP_W  = 32;
    localparam int BOUND_W = 31;

    // Internal widths. A vector component needs 34 signed bits and its
    // magnitude 33 bits. The square of a magnitude needs 66 bits, and the
    // sum of three squares 68 bits.
    localparam int VEC_W   = COMP_W + 2;
    localparam int MAG_W   = VEC_W - 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int BSQ_W   = 2 * BOUND_W;

    // Square root: one result bit per stage.
    localparam int ROOT_W     = SUM_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int REM_W      = ROOT_W + 3;

    // Division of magnitude times bound by the root: one quotient bit per stage.
    localparam int PROD_W    = MAG_W + BOUND_W;
    localparam int QUO_W     = BOUND_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int DREM_W    = ROOT_W + 1;

    // Register stages of one limiter.
    localparam int LIM_LAT = SQRT_STEPS + DIV_STEPS + 6;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [0:0] REG_MAX_SPEED = 1'b0;
    localparam logic [0:0] REG_MAX_DELTA = 1'b1;

    localparam logic [BOUND_W-1:0] MAX_SPEED_RST = BOUND_W'(65536);
    localparam logic [BOUND_W-1:0] MAX_DELTA_RST = BOUND_W'(65536);

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic [2:0][VEC_W-1:0]    vec_t;
    typedef logic [2:0][COMP_W-1:0]   aux_t;

    typedef struct packed {
        logic [BOUND_W-1:0] max_speed;
        logic [BOUND_W-1:0] max_delta;
    } cfg_t;

    typedef struct packed {
        comp_t next_x;
        comp_t next_y;
        comp_t next_z;
    } result_t;

endpackage

`default_nettype wire

// File: design/slv_in_if.sv
`default_nettype none

interface slv_in_if;
    import slv_pkg::*;

    logic  valid;
    logic  ready;
    comp_t current_x;
    comp_t current_y;
    comp_t current_z;
    comp_t desired_x;
    comp_t desired_y;
    comp_t desired_z;

    modport source (
        output valid, current_x, current_y, current_z, desired_x, desired_y, desired_z,
        input  ready
    );

    modport sink (
        input  valid, current_x, current_y, current_z, desired_x, desired_y, desired_z,
        output ready
    );
endinterface

`default_nettype wire

// File: design/slv_out_if.sv
`default_nettype none

interface slv_out_if;
    import slv_pkg::*;

    logic  valid;
    logic  ready;
    comp_t next_x;
    comp_t next_y;
    comp_t next_z;

    modport source (
        output valid, next_x, next_y, next_z,
        input  ready
    );

    modport sink (
        input  valid, next_x, next_y, next_z,
        output ready
    );
endinterface

`default_nettype wire

// File: design/slv_cfg.sv
`default_nettype none

module slv_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [slv_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [slv_pkg::PDATA_W-1:0]  pwdata,
    output logic      [slv_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output slv_pkg::cfg_t                     cfg
);
    import slv_pkg::*;

    logic [BOUND_W-1:0] max_speed_reg;
    logic [BOUND_W-1:0] max_delta_reg;
    logic [0:0]         index;
    logic               wr_en;

    // Registers sit on 4-byte boundaries; bit 2 selects one.
    assign index  = paddr[2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes at the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= MAX_SPEED_RST;
            max_delta_reg <= MAX_DELTA_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_MAX_SPEED: max_speed_reg <= pwdata[BOUND_W-1:0];
                REG_MAX_DELTA: max_delta_reg <= pwdata[BOUND_W-1:0];
                default:       max_speed_reg <= max_speed_reg;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        unique case (index)
            REG_MAX_SPEED: prdata = PDATA_W'(max_speed_reg);
            REG_MAX_DELTA: prdata = PDATA_W'(max_delta_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.max_speed = max_speed_reg;
    assign cfg.max_delta = max_delta_reg;

endmodule

`default_nettype wire

// File: design/slv_limit.sv
`default_nettype none

module slv_limit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic [slv_pkg::BOUND_W-1:0]  bound,
    input  wire logic                         in_valid,
    input  wire slv_pkg::vec_t                in_vec,
    input  wire slv_pkg::aux_t                in_aux,
    output logic                              out_valid,
    output slv_pkg::vec_t                     out_vec,
    output slv_pkg::aux_t                     out_aux
);
    import slv_pkg::*;

    typedef struct packed {
        vec_t v;
        aux_t aux;
    } front_t;

    typedef struct packed {
        vec_t                   v;
        aux_t                   aux;
        logic [2:0][MAG_W-1:0]  mag;
    } mag_st_t;

    typedef struct packed {
        vec_t                   v;
        aux_t                   aux;
        logic [2:0][MAG_W-1:0]  mag;
        logic [2:0][SQ_W-1:0]   sq;
        logic [BSQ_W-1:0]       bsq;
    } sq_st_t;

    typedef struct packed {
        vec_t                   v;
        aux_t                   aux;
        logic [2:0][MAG_W-1:0]  mag;
        logic                   lim;
        logic [SUM_W-1:0]       rad;
        logic [REM_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
    } sqrt_st_t;

    typedef struct packed {
        vec_t                   v;
        aux_t                   aux;
        logic                   lim;
        logic [ROOT_W-1:0]      root;
        logic [2:0][DREM_W-1:0] rem;
        logic [2:0][QUO_W-1:0]  lo;
        logic [2:0][QUO_W-1:0]  quo;
    } div_st_t;

    front_t   st0_reg, st0_next;
    mag_st_t  st1_reg, st1_next;
    sq_st_t   st2_reg, st2_next;
    sqrt_st_t sqr_reg [0:SQRT_STEPS];
    sqrt_st_t sqr_next [0:SQRT_STEPS];
    div_st_t  div_reg [0:DIV_STEPS];
    div_st_t  div_next [0:DIV_STEPS];
    front_t   out_reg, out_next;
    logic [LIM_LAT-1:0] vld_reg, vld_next;

    // Magnitudes of the components.
    always_comb
    begin
        logic [VEC_W-1:0] neg;
        st0_next.v   = in_vec;
        st0_next.aux = in_aux;
        st1_next.v   = st0_reg.v;
        st1_next.aux = st0_reg.aux;
        neg          = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg = ~st0_reg.v[i] + 1'b1;
            st1_next.mag[i] = st0_reg.v[i][VEC_W-1] ? neg[MAG_W-1:0] : st0_reg.v[i][MAG_W-1:0];
        end
    end

    // Squares of the magnitudes and of the bound.
    always_comb
    begin
        st2_next.v   = st1_reg.v;
        st2_next.aux = st1_reg.aux;
        st2_next.mag = st1_reg.mag;
        for (int i = 0; i < 3; i++)
        begin
            st2_next.sq[i] = SQ_W'(st1_reg.mag[i]) * SQ_W'(st1_reg.mag[i]);
        end
        st2_next.bsq = BSQ_W'(bound) * BSQ_W'(bound);
    end

    // Squared length, the exact limit test and the restoring square root.
    always_comb
    begin
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        logic             ge;
        sqr_next[0].v    = st2_reg.v;
        sqr_next[0].aux  = st2_reg.aux;
        sqr_next[0].mag  = st2_reg.mag;
        sqr_next[0].rad  = SUM_W'(st2_reg.sq[0]) + SUM_W'(st2_reg.sq[1])
                         + SUM_W'(st2_reg.sq[2]);
        sqr_next[0].lim  = sqr_next[0].rad > SUM_W'(st2_reg.bsq);
        sqr_next[0].rem  = '0;
        sqr_next[0].root = '0;
        cur   = '0;
        trial = '0;
        ge    = 1'b0;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            cur   = {sqr_reg[k].rem[REM_W-3:0], sqr_reg[k].rad[SUM_W-1 -: 2]};
            trial = REM_W'({sqr_reg[k].root, 2'b01});
            ge    = cur >= trial;
            sqr_next[k+1].v    = sqr_reg[k].v;
            sqr_next[k+1].aux  = sqr_reg[k].aux;
            sqr_next[k+1].mag  = sqr_reg[k].mag;
            sqr_next[k+1].lim  = sqr_reg[k].lim;
            sqr_next[k+1].rad  = {sqr_reg[k].rad[SUM_W-3:0], 2'b00};
            sqr_next[k+1].rem  = ge ? cur - trial : cur;
            sqr_next[k+1].root = {sqr_reg[k].root[ROOT_W-2:0], ge};
        end
    end

    // Magnitude times bound, then one quotient bit per stage.
    always_comb
    begin
        logic [PROD_W-1:0] prod;
        logic [DREM_W-1:0] cur;
        logic [DREM_W-1:0] rext;
        logic              ge;
        div_next[0].v    = sqr_reg[SQRT_STEPS].v;
        div_next[0].aux  = sqr_reg[SQRT_STEPS].aux;
        div_next[0].lim  = sqr_reg[SQRT_STEPS].lim;
        div_next[0].root = sqr_reg[SQRT_STEPS].root;
        prod = '0;
        for (int i = 0; i < 3; i++)
        begin
            prod = PROD_W'(sqr_reg[SQRT_STEPS].mag[i]) * PROD_W'(bound);
            div_next[0].rem[i] = DREM_W'(prod[PROD_W-1:QUO_W]);
            div_next[0].lo[i]  = prod[QUO_W-1:0];
            div_next[0].quo[i] = '0;
        end
        cur  = '0;
        rext = '0;
        ge   = 1'b0;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            div_next[j+1].v    = div_reg[j].v;
            div_next[j+1].aux  = div_reg[j].aux;
            div_next[j+1].lim  = div_reg[j].lim;
            div_next[j+1].root = div_reg[j].root;
            rext = DREM_W'(div_reg[j].root);
            for (int i = 0; i < 3; i++)
            begin
                cur = {div_reg[j].rem[i][DREM_W-2:0], div_reg[j].lo[i][QUO_W-1]};
                ge  = cur >= rext;
                div_next[j+1].rem[i] = ge ? cur - rext : cur;
                div_next[j+1].lo[i]  = {div_reg[j].lo[i][QUO_W-2:0], 1'b0};
                div_next[j+1].quo[i] = {div_reg[j].quo[i][QUO_W-2:0], ge};
            end
        end
    end

    // Restore the signs, or pass the vector through when it is in bounds.
    always_comb
    begin
        logic [VEC_W-1:0] q;
        out_next.aux = div_reg[DIV_STEPS].aux;
        q = '0;
        for (int i = 0; i < 3; i++)
        begin
            q = VEC_W'(div_reg[DIV_STEPS].quo[i]);
            if (!div_reg[DIV_STEPS].lim)
            begin
                out_next.v[i] = div_reg[DIV_STEPS].v[i];
            end
            else if (div_reg[DIV_STEPS].v[i][VEC_W-1])
            begin
                out_next.v[i] = ~q + 1'b1;
            end
            else
            begin
                out_next.v[i] = q;
            end
        end
    end

    // Data stages move together whenever the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st0_reg <= st0_next;
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            for (int k = 0; k <= SQRT_STEPS; k++)
            begin
                sqr_reg[k] <= sqr_next[k];
            end
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                div_reg[j] <= div_next[j];
            end
            out_reg <= out_next;
        end
    end

    // Valid bits travel beside the data.
    assign vld_next = {vld_reg[LIM_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg[LIM_LAT-1];
    assign out_vec   = out_reg.v;
    assign out_aux   = out_reg.aux;

endmodule

`default_nettype wire

// File: design/slv_skid.sv
`default_nettype none

module slv_skid (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire slv_pkg::result_t push_data,
    output logic                  full,
    slv_out_if.source             result
);
    import slv_pkg::*;

    result_t    ent0_reg, ent0_next;
    result_t    ent1_reg, ent1_next;
    logic [1:0] cnt_reg, cnt_next;

    // Two-entry buffer: entry 0 is the head.
    always_comb
    begin
        logic       pop;
        logic [1:0] left;
        pop       = (cnt_reg != 2'd0) && result.ready;
        left      = cnt_reg - {1'b0, pop};
        ent0_next = pop ? ent1_reg : ent0_reg;
        ent1_next = ent1_reg;
        if (push)
        begin
            if (left == 2'd0)
            begin
                ent0_next = push_data;
            end
            else
            begin
                ent1_next = push_data;
            end
        end
        cnt_next = left + {1'b0, push};
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign full         = cnt_reg == 2'd2;
    assign result.valid = cnt_reg != 2'd0;
    assign result.next_x = ent0_reg.next_x;
    assign result.next_y = ent0_reg.next_y;
    assign result.next_z = ent0_reg.next_z;

endmodule

`default_nettype wire

// File: design/vector_velocity_slew_limiter_core.sv
`default_nettype none

// Channel   Direction  Transfer
// item      sink       current_x/y/z, desired_x/y/z (signed Q15.16)
// result    source     next_x/y/z (signed Q15.16)
// APB       slave      max_speed at 0x0, max_delta at 0x4
//
// One transfer is accepted every cycle while the output buffer has room; a
// result passes through three limiters of 71 stages each, set by the 34-stage
// square root and the 31-stage divider, and then through the output buffer.
// Reset clears the valid bits and sets both bounds to 1.0.
// When the two-entry output buffer is full the whole pipeline holds.

module vector_velocity_slew_limiter_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [slv_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [slv_pkg::PDATA_W-1:0]  pwdata,
    output logic      [slv_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    slv_in_if.sink                            item,
    slv_out_if.source                         result
);
    import slv_pkg::*;

    cfg_t    cfg;
    logic    adv;
    logic    full;
    vec_t    des_vec, v1, v2, v3, d_vec, s_vec;
    aux_t    cur_aux, a1, a2;
    logic    vld1, vld2, vld3;
    result_t res;

    slv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The pipeline advances while the output buffer has room.
    assign adv        = !full;
    assign item.ready = adv;

    assign cur_aux = {item.current_z, item.current_y, item.current_x};
    assign des_vec = {VEC_W'(item.desired_z), VEC_W'(item.desired_y), VEC_W'(item.desired_x)};

    // Limit the desired velocity to the maximum speed.
    slv_limit u_lim_des (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .bound     (cfg.max_speed),
        .in_valid  (item.valid),
        .in_vec    (des_vec),
        .in_aux    (cur_aux),
        .out_valid (vld1),
        .out_vec   (v1),
        .out_aux   (a1)
    );

    // Change from the current velocity.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_vec[i] = v1[i] - VEC_W'(signed'(a1[i]));
        end
    end

    slv_limit u_lim_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .bound     (cfg.max_delta),
        .in_valid  (vld1),
        .in_vec    (d_vec),
        .in_aux    (a1),
        .out_valid (vld2),
        .out_vec   (v2),
        .out_aux   (a2)
    );

    // Current velocity plus the limited change.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_vec[i] = v2[i] + VEC_W'(signed'(a2[i]));
        end
    end

    slv_limit u_lim_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .bound     (cfg.max_speed),
        .in_valid  (vld2),
        .in_vec    (s_vec),
        .in_aux    (a2),
        .out_valid (vld3),
        .out_vec   (v3),
        .out_aux   ()
    );

    // Saturate each component to the signed 32-bit range.
    function automatic comp_t sat_comp(input logic [VEC_W-1:0] v);
        logic signed [VEC_W-1:0] s;
        s = signed'(v);
        if (s > VEC_W'(signed'(COMP_W'({1'b0, {(COMP_W-1){1'b1}}}))))
        begin
            return {1'b0, {(COMP_W-1){1'b1}}};
        end
        else if (s < VEC_W'(signed'(COMP_W'({1'b1, {(COMP_W-1){1'b0}}}))))
        begin
            return {1'b1, {(COMP_W-1){1'b0}}};
        end
        return v[COMP_W-1:0];
    endfunction

    assign res.next_x = sat_comp(v3[0]);
    assign res.next_y = sat_comp(v3[1]);
    assign res.next_z = sat_comp(v3[2]);

    slv_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (vld3 && adv),
        .push_data (res),
        .full      (full),
        .result    (result)
    );

endmodule

`default_nettype wire

// File: bench/slv_checker.sv
`default_nettype none

module slv_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic                        pready,
    input  wire logic [slv_pkg::PADDR_W-1:0] paddr,
    input  wire logic [slv_pkg::PDATA_W-1:0] pwdata,
    slv_in_if                                item,
    slv_out_if                               result,
    output int                               errors,
    output int                               pending
);
    import slv_pkg::*;

    typedef logic signed [35:0] wide_t;
    typedef wide_t trip_t [3];

    logic [BOUND_W-1:0] speed_bound;
    logic [BOUND_W-1:0] delta_bound;
    result_t            next_q [$];

    // Scale a vector down to the bound when its exact length exceeds it.
    function automatic trip_t clamp_length(trip_t v, logic [BOUND_W-1:0] bound);
        logic [69:0] sum_sq;
        logic [69:0] trial_sq;
        logic [69:0] quo;
        logic [35:0] mag;
        logic [34:0] root;
        logic [34:0] trial;
        trip_t       o;
        o = v;
        sum_sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag = (v[i] < 0) ? -v[i] : v[i];
            sum_sq += 70'(mag) * 70'(mag);
        end
        if (sum_sq <= 70'(bound) * 70'(bound))
            return o;
        // Bitwise floor square root of the sum of squares.
        root = '0;
        for (int b = 34; b >= 0; b--)
        begin
            trial = root | (35'd1 << b);
            trial_sq = 70'(trial) * 70'(trial);
            if (trial_sq <= sum_sq)
                root = trial;
        end
        // Scale each magnitude, truncating toward zero.
        for (int i = 0; i < 3; i++)
        begin
            mag = (v[i] < 0) ? -v[i] : v[i];
            quo = (70'(mag) * 70'(bound)) / 70'(root);
            o[i] = (v[i] < 0) ? -wide_t'(quo) : wide_t'(quo);
        end
        return o;
    endfunction

    function automatic comp_t saturate(wide_t v);
        if (v > 36'sd2147483647)
            return comp_t'(32'h7fffffff);
        if (v < -36'sd2147483648)
            return comp_t'(32'h80000000);
        return comp_t'(v);
    endfunction

    // Work out the bounded next velocity for one transfer.
    function automatic result_t next_velocity(comp_t cx, comp_t cy, comp_t cz,
                                              comp_t dx, comp_t dy, comp_t dz);
        trip_t   cur;
        trip_t   des;
        trip_t   chg;
        result_t r;
        cur[0] = cx; cur[1] = cy; cur[2] = cz;
        des[0] = dx; des[1] = dy; des[2] = dz;
        des = clamp_length(des, speed_bound);
        for (int i = 0; i < 3; i++)
            chg[i] = des[i] - cur[i];
        chg = clamp_length(chg, delta_bound);
        for (int i = 0; i < 3; i++)
            chg[i] = cur[i] + chg[i];
        chg = clamp_length(chg, speed_bound);
        r.next_x = saturate(chg[0]);
        r.next_y = saturate(chg[1]);
        r.next_z = saturate(chg[2]);
        return r;
    endfunction

    assign pending = next_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            speed_bound = MAX_SPEED_RST;
            delta_bound = MAX_DELTA_RST;
            next_q.delete();
            errors = 0;
        end
        else
        begin
            // Track register writes on the configuration port.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_MAX_SPEED: speed_bound = pwdata[BOUND_W-1:0];
                    REG_MAX_DELTA: delta_bound = pwdata[BOUND_W-1:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                next_q.push_back(next_velocity(item.current_x, item.current_y,
                                               item.current_z, item.desired_x,
                                               item.desired_y, item.desired_z));
            // Compare each result transfer with the oldest expectation.
            if (result.valid && result.ready)
            begin
                if (next_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h %h %h", $time,
                             result.next_x, result.next_y, result.next_z);
                end
                else
                begin
                    want = next_q.pop_front();
                    if (want.next_x !== result.next_x)
                    begin
                        errors++;
                        $display("%0t: next_x expected %h actual %h", $time,
                                 want.next_x, result.next_x);
                    end
                    if (want.next_y !== result.next_y)
                    begin
                        errors++;
                        $display("%0t: next_y expected %h actual %h", $time,
                                 want.next_y, result.next_y);
                    end
                    if (want.next_z !== result.next_z)
                    begin
                        errors++;
                        $display("%0t: next_z expected %h actual %h", $time,
                                 want.next_z, result.next_z);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;
    import slv_pkg::*;

    localparam int DRAIN_CYCLES = 260;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    int                   errors;
    int                   pending;
    int                   hold_len;
    bit                   no_idle;

    slv_in_if  item ();
    slv_out_if result ();

    vector_velocity_slew_limiter_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item),
        .result  (result)
    );

    slv_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .item    (item),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #(20 * 1500000);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: a random hold-off per transfer, or one long stall on request.
    // A requested stall starts at once, even while no result is waiting.
    initial
    begin
        int w;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = no_idle ? 0 : $urandom_range(0, 10);
            if (hold_len > 0)
            begin
                w = hold_len;
                hold_len = 0;
            end
            if (w > 0)
            begin
                result.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid && hold_len == 0);
        end
    end

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 4))
            0: return comp_t'($urandom());
            1: return comp_t'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
            2: return comp_t'($signed($urandom_range(0, 32'h2000000)) - 32'sh1000000);
            3:
            begin
                case ($urandom_range(0, 2))
                    0: return comp_t'(32'h80000000);
                    1: return comp_t'(32'h7fffffff);
                    default: return comp_t'(0);
                endcase
            end
            default: return comp_t'($urandom());
        endcase
    endfunction

    task automatic reg_write(logic [0:0] idx, logic [BOUND_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {1'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One item transfer, after a random gap unless idling is off.
    task automatic send_vel(comp_t cx, comp_t cy, comp_t cz, comp_t dx, comp_t dy,
                            comp_t dz);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid     <= 1'b1;
        item.current_x <= cx;
        item.current_y <= cy;
        item.current_z <= cz;
        item.desired_x <= dx;
        item.desired_y <= dy;
        item.desired_z <= dz;
        do @(posedge clk); while (!item.ready);
    endtask

    task automatic send_random(int n);
        for (int k = 0; k < n; k++)
            send_vel(rand_comp(), rand_comp(), rand_comp(),
                     rand_comp(), rand_comp(), rand_comp());
    endtask

    // Stop offering until every result is back, then let the pipeline settle.
    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_bounds(logic [BOUND_W-1:0] speed, logic [BOUND_W-1:0] delta);
        reg_write(REG_MAX_SPEED, speed);
        reg_write(REG_MAX_DELTA, delta);
    endtask

    initial
    begin
        comp_t mx;
        comp_t mn;
        comp_t one;
        comp_t z;
        mx  = comp_t'(32'h7fffffff);
        mn  = comp_t'(32'h80000000);
        one = comp_t'(32'h00010000);
        z   = comp_t'(0);
        hold_len = 0;
        no_idle  = 1'b0;
        rst_n    = 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        item.valid     <= 1'b0;
        item.current_x <= '0;
        item.current_y <= '0;
        item.current_z <= '0;
        item.desired_x <= '0;
        item.desired_y <= '0;
        item.desired_z <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed vectors at the reset bounds: zero, extremes, small steps.
        send_vel(z, z, z, z, z, z);
        send_vel(mx, mx, mx, mx, mx, mx);
        send_vel(mn, mn, mn, mn, mn, mn);
        send_vel(mn, mn, mn, mx, mx, mx);
        send_vel(mx, mx, mx, mn, mn, mn);
        send_vel(z, z, z, one, z, z);
        send_vel(z, z, z, z, -one, z);
        send_vel(one, z, z, z, z, -one);
        send_vel(z, z, z, comp_t'(32'h8000), comp_t'(32'h8000), z);
        send_vel(z, one, z, z, one, z);
        send_vel(mx, z, mn, z, z, z);
        drain();

        // Zero speed bound, widest delta.
        set_bounds('0, 31'h7fffffff);
        send_vel(z, z, z, z, z, z);
        send_vel(mx, mn, one, one, one, one);
        send_random(20);
        drain();

        // Zero delta bound: the change vanishes.
        set_bounds(31'h7fffffff, '0);
        send_vel(mx, mx, mx, z, z, z);
        send_vel(mn, mn, mn, mx, mx, mx);
        send_random(20);
        drain();

        // Both bounds at the maximum.
        set_bounds(31'h7fffffff, 31'h7fffffff);
        send_vel(mn, mn, mn, mx, mx, mx);
        send_vel(mx, mx, mx, mn, mn, mn);
        send_random(20);
        drain();

        // Smallest nonzero bounds.
        set_bounds(31'd1, 31'd1);
        send_random(20);
        drain();

        // Long stall on the result side while items keep coming back to back;
        // more items are offered than the pipeline and buffer can hold.
        set_bounds(31'h50000, 31'h8000);
        no_idle  = 1'b1;
        hold_len = 600;
        send_random(220);
        no_idle  = 1'b0;
        send_random(10);
        drain();

        // A few random settings.
        for (int p = 0; p < 4; p++)
        begin
            if (p[0])
                set_bounds(31'($urandom()), 31'($urandom()));
            else
                set_bounds(31'($urandom_range(0, 32'h100000)),
                           31'($urandom_range(0, 32'h40000)));
            send_random(15);
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
